### rtl/assert_macros.svh
// Assertion macros for the checker file.
// Needs a clock named clock and a synchronous active-high reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge outside reset.
`define MTS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check prop on every rising edge, reset included.
`define MTS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/mts_pkg.sv
// Shared types and defaults for the monthly temperature statistics block.
// No dependencies; the files that use it refer to it by scoped names.
package mts_pkg;

   localparam int MONTHS_DEFAULT     = 12;
   localparam int COUNT_BITS_DEFAULT = 16;

   typedef struct packed {
      logic [3:0]        month;
      logic signed [7:0] temperature;
      logic              last;
   } mts_req_type;

   typedef struct packed {
      logic [3:0]         bin;
      logic [15:0]        count;
      logic signed [15:0] average;
      logic signed [7:0]  maximum;
      logic signed [7:0]  minimum;
      logic               has_data;
      logic               final_res;
   } mts_rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load_rec;
      logic accum;
      logic month_load;
      logic month_done;
      logic bin_next;
      logic set_load;
      logic set_done;
      logic clear_all;
   } mts_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic rec_last;
      logic bin_empty;
      logic bin_last;
      logic set_empty;
      logic div_done;
   } mts_sts_type;

endpackage

### rtl/mts_divider.sv
// Iterative restoring divider on magnitudes, one quotient bit per cycle.
// Returns a 16-bit signed quotient truncated toward zero. Depends on nothing.
module mts_divider #(
   parameter int DW = 32,
   parameter int VW = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DW-1:0]       dividend,
   input  logic [VW-1:0]       divisor,
   input  logic                negate,
   output logic                done,
   output logic signed [15:0]  quotient
);

   localparam int SCW = $clog2(DW);

   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [SCW-1:0] step_ff, step_in;
   logic [VW-1:0]  rem_ff, rem_in;
   logic [DW-1:0]  quo_ff, quo_in;
   logic [VW-1:0]  div_ff, div_in;
   logic           neg_ff, neg_in;

   logic [VW:0]    shifted;
   logic [VW:0]    diff;
   logic           fits;
   logic [15:0]    mag;

   assign shifted = {rem_ff, quo_ff[DW-1]};
   assign diff    = shifted - {1'b0, div_ff};
   assign fits    = shifted >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         neg_in  = negate;
      end else if (busy_ff) begin
         rem_in = fits ? diff[VW-1:0] : shifted[VW-1:0];
         quo_in = {quo_ff[DW-2:0], fits};
         if (step_ff == SCW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + SCW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      div_ff  <= div_in;
      neg_ff  <= neg_in;
   end

   // Magnitude never exceeds 32768, so 16 bits two's complement are exact.
   assign mag      = quo_ff[15:0];
   assign quotient = neg_ff ? (~mag + 16'd1) : mag;
   assign done     = done_ff;

endmodule

### rtl/mts_datapath.sv
// Datapath: record register, per-month bins, whole-set extremes, result register.
// Uses mts_pkg types and instantiates mts_divider.
module mts_datapath #(
   parameter int MONTHS     = mts_pkg::MONTHS_DEFAULT,
   parameter int COUNT_BITS = mts_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mts_pkg::mts_req_type req_data,
   input  mts_pkg::mts_cmd_type cmd,
   output mts_pkg::mts_sts_type sts,
   output mts_pkg::mts_rsp_type rsp_data
);

   localparam int CB  = COUNT_BITS;
   localparam int SW  = CB + 8;
   localparam int DW  = SW + 8;
   localparam int BW  = (MONTHS > 1) ? $clog2(MONTHS) : 1;
   localparam int BCW = $clog2(MONTHS + 1);
   localparam int ASW = 16 + BCW;
   localparam logic [CB-1:0] COUNT_SAT = {CB{1'b1}};

   mts_pkg::mts_req_type rec_ff;
   mts_pkg::mts_rsp_type rsp_ff;

   logic [CB-1:0]        cnt_ff [MONTHS];
   logic signed [SW-1:0] sum_ff [MONTHS];
   logic signed [7:0]    max_ff [MONTHS];
   logic signed [7:0]    min_ff [MONTHS];
   logic signed [7:0]    set_max_ff;
   logic signed [7:0]    set_min_ff;
   logic                 any_ff;
   logic [BCW-1:0]       bin_ff;
   logic signed [ASW-1:0] avg_sum_ff;
   logic [BCW-1:0]       months_ff;

   logic [3:0]           rec_m1;
   logic                 rec_hit;
   logic [BW-1:0]        idx;
   logic [CB-1:0]        cur_cnt;
   logic signed [SW-1:0] cur_sum;
   logic signed [7:0]    cur_max;
   logic signed [7:0]    cur_min;
   logic signed [7:0]    t;
   logic [SW-1:0]        sum_mag;
   logic [ASW-1:0]       asum_mag;
   logic [CB+15:0]       cnt_wide;
   logic [BCW+15:0]      months_wide;
   logic [BCW+3:0]       bin_wide;
   logic [BCW+3:0]       set_bin_wide;

   logic                 div_start;
   logic [DW-1:0]        div_dividend;
   logic [CB-1:0]        div_divisor;
   logic                 div_negate;
   logic                 div_done;
   logic signed [15:0]   div_quotient;

   assign t       = rec_ff.temperature;
   assign rec_m1  = rec_ff.month - 4'd1;
   assign rec_hit = (rec_ff.month != 4'd0) && ({1'b0, rec_ff.month} <= 5'(MONTHS));
   assign idx     = cmd.accum ? rec_m1[BW-1:0] : bin_ff[BW-1:0];

   assign cur_cnt = cnt_ff[idx];
   assign cur_sum = sum_ff[idx];
   assign cur_max = max_ff[idx];
   assign cur_min = min_ff[idx];

   assign sum_mag      = cur_sum[SW-1] ? -cur_sum : cur_sum;
   assign asum_mag     = avg_sum_ff[ASW-1] ? -avg_sum_ff : avg_sum_ff;
   assign cnt_wide     = {16'd0, cur_cnt};
   assign months_wide  = {16'd0, months_ff};
   assign bin_wide     = {4'd0, bin_ff};
   assign set_bin_wide = {4'd0, BCW'(MONTHS)};

   // Share one divider between month averages and the set average.
   assign div_start    = (cmd.month_load && (cur_cnt != '0)) ||
                         (cmd.set_load && (months_ff != '0));
   assign div_dividend = cmd.set_load ? {{(DW-ASW){1'b0}}, asum_mag} : {sum_mag, 8'd0};
   assign div_divisor  = cmd.set_load ? {{(CB-BCW){1'b0}}, months_ff} : cur_cnt;
   assign div_negate   = cmd.set_load ? avg_sum_ff[ASW-1] : cur_sum[SW-1];

   mts_divider #(
      .DW(DW),
      .VW(CB)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .negate   (div_negate),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) begin
         for (int i = 0; i < MONTHS; i++) begin
            cnt_ff[i] <= '0;
            sum_ff[i] <= '0;
            max_ff[i] <= '0;
            min_ff[i] <= '0;
         end
         set_max_ff <= '0;
         set_min_ff <= '0;
         any_ff     <= 1'b0;
         bin_ff     <= '0;
         avg_sum_ff <= '0;
         months_ff  <= '0;
      end else begin
         if (cmd.accum) begin
            if (!any_ff || (t > set_max_ff)) set_max_ff <= t;
            if (!any_ff || (t < set_min_ff)) set_min_ff <= t;
            any_ff <= 1'b1;
            if (rec_hit && (cur_cnt != COUNT_SAT)) begin
               if ((cur_cnt == '0) || (t > cur_max)) max_ff[idx] <= t;
               if ((cur_cnt == '0) || (t < cur_min)) min_ff[idx] <= t;
               cnt_ff[idx] <= cur_cnt + CB'(1);
               sum_ff[idx] <= cur_sum + SW'(t);
            end
         end
         if (cmd.month_done) begin
            avg_sum_ff <= avg_sum_ff + ASW'(div_quotient);
            months_ff  <= months_ff + BCW'(1);
         end
         if (cmd.bin_next) bin_ff <= bin_ff + BCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rec) rec_ff <= req_data;
      if (cmd.month_load) begin
         rsp_ff.bin       <= bin_wide[3:0];
         rsp_ff.count     <= cnt_wide[15:0];
         rsp_ff.average   <= '0;
         rsp_ff.maximum   <= cur_max;
         rsp_ff.minimum   <= cur_min;
         rsp_ff.has_data  <= cur_cnt != '0;
         rsp_ff.final_res <= 1'b0;
      end else if (cmd.set_load) begin
         rsp_ff.bin       <= set_bin_wide[3:0];
         rsp_ff.count     <= months_wide[15:0];
         rsp_ff.average   <= '0;
         rsp_ff.maximum   <= any_ff ? set_max_ff : 8'sd0;
         rsp_ff.minimum   <= any_ff ? set_min_ff : 8'sd0;
         rsp_ff.has_data  <= any_ff;
         rsp_ff.final_res <= 1'b1;
      end else if (cmd.month_done || cmd.set_done) begin
         rsp_ff.average <= div_quotient;
      end
   end

   assign sts.rec_last  = rec_ff.last;
   assign sts.bin_empty = cur_cnt == '0;
   assign sts.bin_last  = bin_ff == BCW'(MONTHS - 1);
   assign sts.set_empty = months_ff == '0;
   assign sts.div_done  = div_done;

   assign rsp_data = rsp_ff;

endmodule

### rtl/mts_ctrl.sv
// Controller: sequences record capture, accumulation and the result run.
// Uses mts_pkg command and status types.
module mts_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  mts_pkg::mts_sts_type sts,
   output mts_pkg::mts_cmd_type cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ACC   = 3'd1;
   localparam logic [2:0] S_MLOAD = 3'd2;
   localparam logic [2:0] S_MDIV  = 3'd3;
   localparam logic [2:0] S_MOUT  = 3'd4;
   localparam logic [2:0] S_SLOAD = 3'd5;
   localparam logic [2:0] S_SDIV  = 3'd6;
   localparam logic [2:0] S_SOUT  = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = (state_ff == S_MOUT) || (state_ff == S_SOUT);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_rec = 1'b1;
               state_in     = S_ACC;
            end
         end
         S_ACC: begin
            cmd.accum = 1'b1;
            state_in  = sts.rec_last ? S_MLOAD : S_IDLE;
         end
         S_MLOAD: begin
            cmd.month_load = 1'b1;
            state_in       = sts.bin_empty ? S_MOUT : S_MDIV;
         end
         S_MDIV: begin
            if (sts.div_done) begin
               cmd.month_done = 1'b1;
               state_in       = S_MOUT;
            end
         end
         S_MOUT: begin
            if (rsp_ready) begin
               cmd.bin_next = 1'b1;
               state_in     = sts.bin_last ? S_SLOAD : S_MLOAD;
            end
         end
         S_SLOAD: begin
            cmd.set_load = 1'b1;
            state_in     = sts.set_empty ? S_SOUT : S_SDIV;
         end
         S_SDIV: begin
            if (sts.div_done) begin
               cmd.set_done = 1'b1;
               state_in     = S_SOUT;
            end
         end
         S_SOUT: begin
            if (rsp_ready) begin
               cmd.clear_all = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/monthly_temperature_statistics_top.sv
// Monthly temperature statistics, top level. Every accepted record beat is first
// captured and then folded into its month bin and the whole-set minimum and
// maximum. A record with last set then starts the result run: each month bin
// yields one rsp beat, then a whole-set beat with final_res set, and all state
// clears. Averages come from one shared restoring divider that retires one quotient
// bit per cycle; a month with data is loaded, divided and then offered, an empty
// month skips the division, and so does the whole-set beat if no month had data.
// Each beat waits while rsp_ready is low. No new record is taken during the run.
// Depends on mts_pkg, mts_ctrl, mts_datapath and mts_divider.
module monthly_temperature_statistics_top #(
   parameter int MONTHS     = mts_pkg::MONTHS_DEFAULT,
   parameter int COUNT_BITS = mts_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mts_pkg::mts_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mts_pkg::mts_rsp_type rsp_data
);

   // Command and status between sequencer and datapath.
   mts_pkg::mts_cmd_type cmd;
   mts_pkg::mts_sts_type sts;

   // Sequencer: owns the handshakes, never touches payload.
   mts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: bins, extremes, divider and the result register that drives rsp_data.
   mts_datapath #(
      .MONTHS     (MONTHS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

### rtl/mts_checker.sv
// Port-level checks for the statistics block, attached to the top level by bind.
// Uses assert_macros.svh and mts_pkg types.
`include "assert_macros.svh"

module mts_checker #(
   parameter int MONTHS = mts_pkg::MONTHS_DEFAULT
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input mts_pkg::mts_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input mts_pkg::mts_rsp_type rsp_data
);

   // Hold a stalled result beat unchanged.
   `MTS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "rsp beat changed while stalled")

   // Never take a record while a result is offered.
   `MTS_ASSERT(a_no_overlap, !(req_ready && rsp_valid), "record taken during result run")

   // The closing beat always carries the whole-set bin.
   `MTS_ASSERT(a_final_bin, rsp_valid && rsp_data.final_res |-> rsp_data.bin == 4'(MONTHS), "final beat with wrong bin")

   // An empty month reports all zero statistics.
   `MTS_ASSERT(a_empty_month, rsp_valid && !rsp_data.final_res && !rsp_data.has_data |-> rsp_data.count == 16'd0 && rsp_data.average == 16'sd0 && rsp_data.maximum == 8'sd0 && rsp_data.minimum == 8'sd0, "empty month with nonzero fields")

   // Drop any result offer after reset.
   `MTS_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "result offered right after reset")

endmodule

bind monthly_temperature_statistics_top mts_checker #(.MONTHS(MONTHS)) u_mts_checker (.*);
